// ===== design/bgcd_pkg.sv =====
`default_nettype none

package bgcd_pkg;

    localparam int SAMPLE_BITS           = 13;
    localparam int FRACTION_BITS_DEFAULT = 8;
    localparam int GAIN_BITS             = 16;
    localparam int PCT_BITS              = 7;
    localparam int PCT_FRAC_BITS         = 16;
    localparam int MUL_B_BITS            = 24;
    localparam int ROUND_HALF            = 32768;
    localparam int CFG_INDEX_BITS        = 3;
    localparam int CFG_DATA_BITS         = 16;

    localparam int KNEE_FULL_MV  = 4150;
    localparam int KNEE_HIGH_MV  = 4000;
    localparam int KNEE_MID_MV   = 3700;
    localparam int KNEE_LOW_MV   = 3500;
    localparam int KNEE_EMPTY_MV = 3300;

    localparam int SLOPE_HIGH  = 133;
    localparam int SLOPE_MID   = 133;
    localparam int SLOPE_LOW   = 150;
    localparam int SLOPE_EMPTY = 50;

    localparam int BASE_HIGH  = 80;
    localparam int BASE_MID   = 40;
    localparam int BASE_LOW   = 10;
    localparam int BASE_EMPTY = 0;
    localparam int PCT_FULL   = 100;

    // floor(q / 1000) = (q * DIV_RECIP) >> DIV_SHIFT, exact for q below 2**22
    localparam int DIV_RECIP = 4294968;
    localparam int DIV_SHIFT = 32;
    localparam int SEG_Q_BITS = 17;
    localparam int SEG_FRAC_BITS = 6;

    localparam int ICON_QUARTER_PCT = 25;
    localparam int ICON_HALF_PCT    = 50;
    localparam int ICON_THREE_PCT   = 75;
    localparam int LOW_LIMIT_PCT    = 15;

    typedef enum logic [2:0] {
        ICON_EMPTY         = 3'd0,
        ICON_QUARTER       = 3'd1,
        ICON_HALF          = 3'd2,
        ICON_THREE_QUARTER = 3'd3,
        ICON_FULL          = 3'd4
    } icon_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FILTER_GAIN     = 3'd0,
        REG_SMOOTH_GAIN     = 3'd1,
        REG_RISE_THRESHOLD  = 3'd2,
        REG_FALL_THRESHOLD  = 3'd3,
        REG_CHARGER_LEVEL   = 3'd4,
        REG_BOOT_LEVEL      = 3'd5,
        REG_CHARGING_OFFSET = 3'd6,
        REG_RESTING_OFFSET  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] filter_gain;
        logic [15:0] smooth_gain;
        logic [7:0]  rise_threshold_mv;
        logic [7:0]  fall_threshold_mv;
        logic [12:0] charger_level_mv;
        logic [12:0] boot_level_mv;
        logic [10:0] charging_offset_mv;
        logic [8:0]  resting_offset_mv;
    } cfg_t;

    localparam logic [15:0] FILTER_GAIN_RST     = 16'd6554;
    localparam logic [15:0] SMOOTH_GAIN_RST     = 16'd3277;
    localparam logic [7:0]  RISE_THRESHOLD_RST  = 8'd12;
    localparam logic [7:0]  FALL_THRESHOLD_RST  = 8'd15;
    localparam logic [12:0] CHARGER_LEVEL_RST   = 13'd4280;
    localparam logic [12:0] BOOT_LEVEL_RST      = 13'd4220;
    localparam logic [10:0] CHARGING_OFFSET_RST = 11'd800;
    localparam logic [8:0]  RESTING_OFFSET_RST  = 9'd70;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_mv;
        logic                   manual_charging;
    } in_t;

    typedef struct packed {
        logic                charging;
        logic                auto_charging;
        logic [PCT_BITS-1:0] level_percent;
        logic [PCT_BITS-1:0] shown_percent;
        logic [2:0]          icon_level;
        logic                low_battery;
    } out_t;

endpackage

`default_nettype wire

// ===== design/bgcd_regs.sv =====
`default_nettype none

module bgcd_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [bgcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [bgcd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output bgcd_pkg::cfg_t                           cfg
);

    bgcd_pkg::cfg_t cfg_reg;
    bgcd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                bgcd_pkg::REG_FILTER_GAIN:     cfg_next.filter_gain        = cfg_data;
                bgcd_pkg::REG_SMOOTH_GAIN:     cfg_next.smooth_gain        = cfg_data;
                bgcd_pkg::REG_RISE_THRESHOLD:  cfg_next.rise_threshold_mv  = cfg_data[7:0];
                bgcd_pkg::REG_FALL_THRESHOLD:  cfg_next.fall_threshold_mv  = cfg_data[7:0];
                bgcd_pkg::REG_CHARGER_LEVEL:   cfg_next.charger_level_mv   = cfg_data[12:0];
                bgcd_pkg::REG_BOOT_LEVEL:      cfg_next.boot_level_mv      = cfg_data[12:0];
                bgcd_pkg::REG_CHARGING_OFFSET: cfg_next.charging_offset_mv = cfg_data[10:0];
                bgcd_pkg::REG_RESTING_OFFSET:  cfg_next.resting_offset_mv  = cfg_data[8:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_gain        <= bgcd_pkg::FILTER_GAIN_RST;
            cfg_reg.smooth_gain        <= bgcd_pkg::SMOOTH_GAIN_RST;
            cfg_reg.rise_threshold_mv  <= bgcd_pkg::RISE_THRESHOLD_RST;
            cfg_reg.fall_threshold_mv  <= bgcd_pkg::FALL_THRESHOLD_RST;
            cfg_reg.charger_level_mv   <= bgcd_pkg::CHARGER_LEVEL_RST;
            cfg_reg.boot_level_mv      <= bgcd_pkg::BOOT_LEVEL_RST;
            cfg_reg.charging_offset_mv <= bgcd_pkg::CHARGING_OFFSET_RST;
            cfg_reg.resting_offset_mv  <= bgcd_pkg::RESTING_OFFSET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/bgcd_mul.sv =====
`default_nettype none

module bgcd_mul #(
    parameter int A_BITS = 24,
    parameter int B_BITS = 24
) (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic signed [A_BITS-1:0]        a,
    input  wire logic signed [B_BITS-1:0]        b,
    output logic signed [A_BITS+B_BITS-1:0]      prod
);

    logic signed [A_BITS+B_BITS-1:0] prod_reg;
    logic signed [A_BITS+B_BITS-1:0] prod_next;

    always_comb
    begin
        prod_next = prod_reg;
        if (en)
        begin
            prod_next = a * b;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== design/bgcd_core.sv =====
`default_nettype none

module bgcd_core #(
    parameter int FRACTION_BITS = bgcd_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bgcd_pkg::cfg_t       cfg,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire bgcd_pkg::in_t        in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output bgcd_pkg::out_t            out_data
);

    localparam int SB  = bgcd_pkg::SAMPLE_BITS;
    localparam int VW  = SB + FRACTION_BITS;
    localparam int MB  = bgcd_pkg::MUL_B_BITS;
    localparam int MA  = (VW + 1 > MB) ? VW + 1 : MB;
    localparam int PW  = MA + MB;
    localparam int PB  = bgcd_pkg::PCT_BITS;
    localparam int PF  = bgcd_pkg::PCT_FRAC_BITS;
    localparam int SPW = PB + PF;
    localparam int GB  = bgcd_pkg::GAIN_BITS;
    localparam int QB  = bgcd_pkg::SEG_Q_BITS;
    localparam int DS  = bgcd_pkg::DIV_SHIFT;
    localparam int SF  = bgcd_pkg::SEG_FRAC_BITS;

    localparam logic signed [VW+1:0] K_FULL  = (VW+2)'(bgcd_pkg::KNEE_FULL_MV) << FRACTION_BITS;
    localparam logic signed [VW+1:0] K_HIGH  = (VW+2)'(bgcd_pkg::KNEE_HIGH_MV) << FRACTION_BITS;
    localparam logic signed [VW+1:0] K_MID   = (VW+2)'(bgcd_pkg::KNEE_MID_MV) << FRACTION_BITS;
    localparam logic signed [VW+1:0] K_LOW   = (VW+2)'(bgcd_pkg::KNEE_LOW_MV) << FRACTION_BITS;
    localparam logic signed [VW+1:0] K_EMPTY = (VW+2)'(bgcd_pkg::KNEE_EMPTY_MV) << FRACTION_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_FUPD,
        ST_MAP,
        ST_SEG,
        ST_DIV,
        ST_PCT,
        ST_SMUL,
        ST_SUPD,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [SB-1:0]       sample_reg, sample_next;
    logic                manual_reg, manual_next;
    logic [VW-1:0]       filt_reg, filt_next;
    logic [VW-1:0]       prev_reg, prev_next;
    logic                flag_reg, flag_next;
    logic                first_reg, first_next;
    logic [SPW-1:0]      smooth_reg, smooth_next;
    logic                svalid_reg, svalid_next;
    logic [PB-1:0]       seg_base_reg, seg_base_next;
    logic [7:0]          seg_slope_reg, seg_slope_next;
    logic [VW-1:0]       seg_d_reg, seg_d_next;
    logic                seg_fixed_reg, seg_fixed_next;
    logic [PB-1:0]       pct_reg, pct_next;
    bgcd_pkg::out_t      res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    bgcd_pkg::out_t      out_data_reg, out_data_next;

    logic                    mul_en;
    logic signed [MA-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    prod_rnd;

    logic [VW-1:0]           raw_in, raw;
    logic signed [VW:0]      fdiff;
    logic [VW-1:0]           f_new;
    logic signed [VW+1:0]    vc;
    logic signed [VW+1:0]    knee_sel;
    logic signed [VW+1:0]    seg_diff;
    logic [PB-1:0]           base_sel;
    logic [7:0]              slope_sel;
    logic                    fixed_sel;
    logic [QB-1:0]           seg_q;
    logic [SF-1:0]           pct_frac;
    logic [PB:0]             pct_sum;
    logic [PB-1:0]           pct_val;
    logic signed [SPW:0]     sdiff;
    logic [SPW-1:0]          sp_new;
    logic [SPW:0]            sp_up;
    logic [PB:0]             shown_raw;
    logic [PB-1:0]           shown;
    logic signed [VW:0]      tdiff;
    logic signed [VW:0]      rise_q;
    logic signed [VW:0]      fall_q;
    logic                    trend_flag;
    logic [2:0]              icon;

    bgcd_mul #(
        .A_BITS (MA),
        .B_BITS (MB)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign raw_in = {in_data.sample_mv, {FRACTION_BITS{1'b0}}};
    assign raw    = {sample_reg, {FRACTION_BITS{1'b0}}};
    assign fdiff  = $signed({1'b0, raw}) - $signed({1'b0, filt_reg});

    // round to nearest on the Q0.16 gain product
    assign prod_rnd = (prod + $signed(PW'(bgcd_pkg::ROUND_HALF))) >>> GB;
    assign f_new    = VW'($signed({1'b0, filt_reg}) + $signed(prod_rnd[VW:0]));

    always_comb
    begin
        if (flag_reg || manual_reg)
        begin
            vc = $signed({2'b00, filt_reg})
                - $signed((VW+2)'({cfg.charging_offset_mv, {FRACTION_BITS{1'b0}}}));
        end
        else
        begin
            vc = $signed({2'b00, filt_reg})
                + $signed((VW+2)'({cfg.resting_offset_mv, {FRACTION_BITS{1'b0}}}));
        end
    end

    always_comb
    begin
        fixed_sel = 1'b0;
        knee_sel  = K_EMPTY;
        base_sel  = PB'(bgcd_pkg::BASE_EMPTY);
        slope_sel = 8'(bgcd_pkg::SLOPE_EMPTY);
        if (vc >= K_FULL)
        begin
            fixed_sel = 1'b1;
            base_sel  = PB'(bgcd_pkg::PCT_FULL);
        end
        else if (vc >= K_HIGH)
        begin
            knee_sel  = K_HIGH;
            base_sel  = PB'(bgcd_pkg::BASE_HIGH);
            slope_sel = 8'(bgcd_pkg::SLOPE_HIGH);
        end
        else if (vc >= K_MID)
        begin
            knee_sel  = K_MID;
            base_sel  = PB'(bgcd_pkg::BASE_MID);
            slope_sel = 8'(bgcd_pkg::SLOPE_MID);
        end
        else if (vc >= K_LOW)
        begin
            knee_sel  = K_LOW;
            base_sel  = PB'(bgcd_pkg::BASE_LOW);
            slope_sel = 8'(bgcd_pkg::SLOPE_LOW);
        end
        else if (vc < K_EMPTY)
        begin
            fixed_sel = 1'b1;
        end
    end

    assign seg_diff = vc - knee_sel;
    assign seg_q    = prod[FRACTION_BITS+QB-1:FRACTION_BITS];
    assign pct_frac = prod[DS+SF-1:DS];
    assign pct_sum  = {1'b0, seg_base_reg} + (PB+1)'(pct_frac);

    always_comb
    begin
        if (seg_fixed_reg)
        begin
            pct_val = seg_base_reg;
        end
        else if (pct_sum > (PB+1)'(bgcd_pkg::PCT_FULL))
        begin
            pct_val = PB'(bgcd_pkg::PCT_FULL);
        end
        else
        begin
            pct_val = pct_sum[PB-1:0];
        end
    end

    assign sdiff     = $signed({1'b0, pct_reg, {PF{1'b0}}}) - $signed({1'b0, smooth_reg});
    assign sp_new    = SPW'($signed({1'b0, smooth_reg}) + $signed(prod_rnd[SPW:0]));
    assign sp_up     = {1'b0, sp_new} + (SPW+1)'(bgcd_pkg::ROUND_HALF);
    assign shown_raw = sp_up[SPW:PF];
    assign shown     = (shown_raw > (PB+1)'(bgcd_pkg::PCT_FULL))
                       ? PB'(bgcd_pkg::PCT_FULL) : shown_raw[PB-1:0];

    assign tdiff  = $signed({1'b0, filt_reg}) - $signed({1'b0, prev_reg});
    assign rise_q = (VW+1)'({cfg.rise_threshold_mv, {FRACTION_BITS{1'b0}}});
    assign fall_q = (VW+1)'({cfg.fall_threshold_mv, {FRACTION_BITS{1'b0}}});

    always_comb
    begin
        trend_flag = flag_reg;
        if (tdiff > rise_q)
        begin
            trend_flag = 1'b1;
        end
        else if (tdiff < -fall_q)
        begin
            trend_flag = 1'b0;
        end
        if (filt_reg > VW'({cfg.charger_level_mv, {FRACTION_BITS{1'b0}}}))
        begin
            trend_flag = 1'b1;
        end
    end

    always_comb
    begin
        if (pct_reg >= PB'(bgcd_pkg::PCT_FULL))
        begin
            icon = bgcd_pkg::ICON_FULL;
        end
        else if (pct_reg >= PB'(bgcd_pkg::ICON_THREE_PCT))
        begin
            icon = bgcd_pkg::ICON_THREE_QUARTER;
        end
        else if (pct_reg >= PB'(bgcd_pkg::ICON_HALF_PCT))
        begin
            icon = bgcd_pkg::ICON_HALF;
        end
        else if (pct_reg >= PB'(bgcd_pkg::ICON_QUARTER_PCT))
        begin
            icon = bgcd_pkg::ICON_QUARTER;
        end
        else
        begin
            icon = bgcd_pkg::ICON_EMPTY;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        manual_next    = manual_reg;
        filt_next      = filt_reg;
        prev_next      = prev_reg;
        flag_next      = flag_reg;
        first_next     = first_reg;
        smooth_next    = smooth_reg;
        svalid_next    = svalid_reg;
        seg_base_next  = seg_base_reg;
        seg_slope_next = seg_slope_reg;
        seg_d_next     = seg_d_reg;
        seg_fixed_next = seg_fixed_reg;
        pct_next       = pct_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = in_data.sample_mv;
                    manual_next = in_data.manual_charging;
                    filt_next   = (filt_reg == '0) ? raw_in : filt_reg;
                    state_next  = ST_FILT;
                end
            end
            ST_FILT:
            begin
                mul_en     = 1'b1;
                mul_a      = MA'(fdiff);
                mul_b      = MB'(cfg.filter_gain);
                state_next = ST_FUPD;
            end
            ST_FUPD:
            begin
                filt_next = f_new;
                if (first_reg)
                begin
                    prev_next  = f_new;
                    first_next = 1'b0;
                    if (f_new > VW'({cfg.boot_level_mv, {FRACTION_BITS{1'b0}}}))
                    begin
                        flag_next = 1'b1;
                    end
                end
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                seg_fixed_next = fixed_sel;
                seg_base_next  = base_sel;
                seg_slope_next = slope_sel;
                seg_d_next     = seg_diff[VW-1:0];
                state_next     = ST_SEG;
            end
            ST_SEG:
            begin
                mul_en     = 1'b1;
                mul_a      = MA'({1'b0, seg_d_reg});
                mul_b      = MB'(seg_slope_reg);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                mul_en     = 1'b1;
                mul_a      = MA'(seg_q);
                mul_b      = MB'(bgcd_pkg::DIV_RECIP);
                state_next = ST_PCT;
            end
            ST_PCT:
            begin
                pct_next = pct_val;
                if (!svalid_reg)
                begin
                    smooth_next = {pct_val, {PF{1'b0}}};
                    svalid_next = 1'b1;
                end
                state_next = ST_SMUL;
            end
            ST_SMUL:
            begin
                mul_en     = 1'b1;
                mul_a      = MA'(sdiff);
                mul_b      = MB'(cfg.smooth_gain);
                state_next = ST_SUPD;
            end
            ST_SUPD:
            begin
                smooth_next            = sp_new;
                prev_next              = filt_reg;
                flag_next              = trend_flag;
                res_next.charging      = trend_flag || manual_reg;
                res_next.auto_charging = trend_flag;
                res_next.level_percent = pct_reg;
                res_next.shown_percent = shown;
                res_next.icon_level    = icon;
                res_next.low_battery   = (pct_reg <= PB'(bgcd_pkg::LOW_LIMIT_PCT));
                state_next             = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sample_reg    <= '0;
            manual_reg    <= 1'b0;
            filt_reg      <= '0;
            prev_reg      <= '0;
            flag_reg      <= 1'b0;
            first_reg     <= 1'b1;
            smooth_reg    <= '0;
            svalid_reg    <= 1'b0;
            seg_base_reg  <= '0;
            seg_slope_reg <= '0;
            seg_d_reg     <= '0;
            seg_fixed_reg <= 1'b0;
            pct_reg       <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sample_reg    <= sample_next;
            manual_reg    <= manual_next;
            filt_reg      <= filt_next;
            prev_reg      <= prev_next;
            flag_reg      <= flag_next;
            first_reg     <= first_next;
            smooth_reg    <= smooth_next;
            svalid_reg    <= svalid_next;
            seg_base_reg  <= seg_base_next;
            seg_slope_reg <= seg_slope_next;
            seg_d_reg     <= seg_d_next;
            seg_fixed_reg <= seg_fixed_next;
            pct_reg       <= pct_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_FILT)
        else $error("accepted transfer did not start the sequence");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.level_percent <= PB'(bgcd_pkg::PCT_FULL)
                   && out_data.shown_percent <= PB'(bgcd_pkg::PCT_FULL))
        else $error("percentage out of range");

    a_charging: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.auto_charging |-> out_data.charging)
        else $error("charging flag lost detected state");

    a_first_once: assert property (@(posedge clk) disable iff (!rst_n)
        !first_reg |=> !first_reg)
        else $error("first-sample flag came back");

endmodule

`default_nettype wire

// ===== design/battery_gauge_charge_detect.sv =====
`default_nettype none

// Battery gauge with charge detection. Each input transfer carries one raw
// millivolt sample and a manual charging bit; each one yields exactly one
// result transfer with the charge state, the raw and smoothed percentage, an
// icon level and a low-battery flag. A single shared signed multiplier is
// stepped through the voltage filter, the segment slope, the divide by 1000
// and the percentage smoothing, so in_stall stays high while an item is in
// flight, and the block takes no new item until it is done; a held result
// delays the next item until it moves to the output register.
// Configuration registers are to be written through cfg_write/cfg_index/
// cfg_data only while no item is in flight; the block does not enforce this.

module battery_gauge_charge_detect #(
    parameter int FRACTION_BITS = bgcd_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [bgcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [bgcd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire bgcd_pkg::in_t                       in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output bgcd_pkg::out_t                           out_data
);

    bgcd_pkg::cfg_t cfg;

    bgcd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgcd_core #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== tb/tb_battery_gauge_charge_detect.sv =====
`default_nettype none

module tb_battery_gauge_charge_detect;

    localparam int FRAC = bgcd_pkg::FRACTION_BITS_DEFAULT;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 244;
    localparam int DIRECTED_ITEMS = 22;
    localparam int IDLE_PCT = 23;
    localparam int STUCK_LIMIT = 5000;

    class gauge_checker;
        bgcd_pkg::cfg_t regs;
        bit [63:0] volt_q8;
        bit [63:0] last_volt_q8;
        bit [63:0] pct_q16;
        bit auto_flag;
        bit boot_pending;
        bit pct_seeded;
        bgcd_pkg::out_t expected_readings[$];
        int failures;

        function new();
            regs.filter_gain = bgcd_pkg::FILTER_GAIN_RST;
            regs.smooth_gain = bgcd_pkg::SMOOTH_GAIN_RST;
            regs.rise_threshold_mv = bgcd_pkg::RISE_THRESHOLD_RST;
            regs.fall_threshold_mv = bgcd_pkg::FALL_THRESHOLD_RST;
            regs.charger_level_mv = bgcd_pkg::CHARGER_LEVEL_RST;
            regs.boot_level_mv = bgcd_pkg::BOOT_LEVEL_RST;
            regs.charging_offset_mv = bgcd_pkg::CHARGING_OFFSET_RST;
            regs.resting_offset_mv = bgcd_pkg::RESTING_OFFSET_RST;
            volt_q8 = 0;
            last_volt_q8 = 0;
            pct_q16 = 0;
            auto_flag = 1'b0;
            boot_pending = 1'b1;
            pct_seeded = 1'b0;
            failures = 0;
        endfunction

        function void set_register(bgcd_pkg::cfg_reg_t idx, logic [15:0] v);
            case (idx)
                bgcd_pkg::REG_FILTER_GAIN:     regs.filter_gain = v;
                bgcd_pkg::REG_SMOOTH_GAIN:     regs.smooth_gain = v;
                bgcd_pkg::REG_RISE_THRESHOLD:  regs.rise_threshold_mv = v[7:0];
                bgcd_pkg::REG_FALL_THRESHOLD:  regs.fall_threshold_mv = v[7:0];
                bgcd_pkg::REG_CHARGER_LEVEL:   regs.charger_level_mv = v[12:0];
                bgcd_pkg::REG_BOOT_LEVEL:      regs.boot_level_mv = v[12:0];
                bgcd_pkg::REG_CHARGING_OFFSET: regs.charging_offset_mv = v[10:0];
                bgcd_pkg::REG_RESTING_OFFSET:  regs.resting_offset_mv = v[8:0];
                default: ;
            endcase
        endfunction

        function longint mv(int unsigned x);
            return longint'(x) * (longint'(1) << FRAC);
        endfunction

        function bit [63:0] mix(bit [63:0] prev, bit [63:0] fresh, bit [15:0] g);
            bit [63:0] gg;
            gg = g;
            return (prev * (64'd65536 - gg) + fresh * gg + 64'd32768) >> 16;
        endfunction

        function int seg(longint vc, int knee, int base, int slope);
            longint d;
            d = vc - mv(knee);
            return base + int'((d * slope) / (longint'(1000) << FRAC));
        endfunction

        function int percent_of(longint vc);
            int p;
            if (vc >= mv(bgcd_pkg::KNEE_FULL_MV))
                p = bgcd_pkg::PCT_FULL;
            else if (vc >= mv(bgcd_pkg::KNEE_HIGH_MV))
                p = seg(vc, bgcd_pkg::KNEE_HIGH_MV, bgcd_pkg::BASE_HIGH, bgcd_pkg::SLOPE_HIGH);
            else if (vc >= mv(bgcd_pkg::KNEE_MID_MV))
                p = seg(vc, bgcd_pkg::KNEE_MID_MV, bgcd_pkg::BASE_MID, bgcd_pkg::SLOPE_MID);
            else if (vc >= mv(bgcd_pkg::KNEE_LOW_MV))
                p = seg(vc, bgcd_pkg::KNEE_LOW_MV, bgcd_pkg::BASE_LOW, bgcd_pkg::SLOPE_LOW);
            else if (vc >= mv(bgcd_pkg::KNEE_EMPTY_MV))
                p = seg(vc, bgcd_pkg::KNEE_EMPTY_MV, bgcd_pkg::BASE_EMPTY,
                        bgcd_pkg::SLOPE_EMPTY);
            else
                p = 0;
            return (p > bgcd_pkg::PCT_FULL) ? bgcd_pkg::PCT_FULL : p;
        endfunction

        function void note_sample(bgcd_pkg::in_t s);
            bit [63:0] raw;
            bit [63:0] rounded;
            longint f;
            longint vc;
            longint diff;
            int pct;
            bgcd_pkg::icon_t ic;
            bgcd_pkg::out_t r;
            raw = s.sample_mv;
            raw = raw << FRAC;
            if (volt_q8 == 0) volt_q8 = raw;
            volt_q8 = mix(volt_q8, raw, regs.filter_gain);
            f = longint'(volt_q8);
            if (boot_pending)
            begin
                last_volt_q8 = volt_q8;
                if (f > mv(regs.boot_level_mv)) auto_flag = 1'b1;
                boot_pending = 1'b0;
            end
            if (auto_flag || s.manual_charging) vc = f - mv(regs.charging_offset_mv);
            else vc = f + mv(regs.resting_offset_mv);
            pct = percent_of(vc);
            if (!pct_seeded)
            begin
                pct_q16 = 64'(pct) << 16;
                pct_seeded = 1'b1;
            end
            pct_q16 = mix(pct_q16, 64'(pct) << 16, regs.smooth_gain);
            rounded = (pct_q16 + bgcd_pkg::ROUND_HALF) >> 16;
            if (rounded > bgcd_pkg::PCT_FULL) rounded = bgcd_pkg::PCT_FULL;
            // trend update comes after the offset correction
            diff = f - longint'(last_volt_q8);
            last_volt_q8 = volt_q8;
            if (diff > mv(regs.rise_threshold_mv)) auto_flag = 1'b1;
            else if (diff < -mv(regs.fall_threshold_mv)) auto_flag = 1'b0;
            if (f > mv(regs.charger_level_mv)) auto_flag = 1'b1;
            if (pct >= bgcd_pkg::PCT_FULL) ic = bgcd_pkg::ICON_FULL;
            else if (pct >= bgcd_pkg::ICON_THREE_PCT) ic = bgcd_pkg::ICON_THREE_QUARTER;
            else if (pct >= bgcd_pkg::ICON_HALF_PCT) ic = bgcd_pkg::ICON_HALF;
            else if (pct >= bgcd_pkg::ICON_QUARTER_PCT) ic = bgcd_pkg::ICON_QUARTER;
            else ic = bgcd_pkg::ICON_EMPTY;
            r.charging = auto_flag | s.manual_charging;
            r.auto_charging = auto_flag;
            r.level_percent = pct[bgcd_pkg::PCT_BITS-1:0];
            r.shown_percent = rounded[bgcd_pkg::PCT_BITS-1:0];
            r.icon_level = ic;
            r.low_battery = (pct <= bgcd_pkg::LOW_LIMIT_PCT);
            expected_readings.push_back(r);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                failures++;
            end
        endfunction

        function void check_reading(bgcd_pkg::out_t got);
            bgcd_pkg::out_t want;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: reading with none expected, actual %h", $time, got);
                failures++;
                return;
            end
            want = expected_readings.pop_front();
            compare_field("charging", want.charging, got.charging);
            compare_field("auto_charging", want.auto_charging, got.auto_charging);
            compare_field("level_percent", want.level_percent, got.level_percent);
            compare_field("shown_percent", want.shown_percent, got.shown_percent);
            compare_field("icon_level", want.icon_level, got.icon_level);
            compare_field("low_battery", want.low_battery, got.low_battery);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_write;
    logic [bgcd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [bgcd_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    bgcd_pkg::in_t                       in_data;
    logic                                out_valid;
    logic                                out_stall;
    bgcd_pkg::out_t                      out_data;

    gauge_checker gauge;
    bit steady;
    int track_mv;
    int zero_run;
    int stuck_cycles;

    battery_gauge_charge_detect u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic write_register(input bgcd_pkg::cfg_reg_t idx, input logic [15:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        gauge.set_register(idx, v);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // stall is stable between edges, so it is looked at on the falling edge
    task automatic send_sample(input bgcd_pkg::in_t s);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= s;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        gauge.note_sample(s);
    endtask

    task automatic wait_drained();
        while (gauge.pending() != 0)
            @(posedge clk);
    endtask

    task automatic program_phase(input int p);
        bgcd_pkg::cfg_t c;
        case (p)
            1:
            begin
                c = '1;
            end
            3:
            begin
                c = '0;
            end
            4:
            begin
                c.filter_gain = bgcd_pkg::FILTER_GAIN_RST;
                c.smooth_gain = bgcd_pkg::SMOOTH_GAIN_RST;
                c.rise_threshold_mv = bgcd_pkg::RISE_THRESHOLD_RST;
                c.fall_threshold_mv = bgcd_pkg::FALL_THRESHOLD_RST;
                c.charger_level_mv = bgcd_pkg::CHARGER_LEVEL_RST;
                c.boot_level_mv = bgcd_pkg::BOOT_LEVEL_RST;
                c.charging_offset_mv = bgcd_pkg::CHARGING_OFFSET_RST;
                c.resting_offset_mv = bgcd_pkg::RESTING_OFFSET_RST;
            end
            default:
            begin
                c.filter_gain = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(3000, 30000));
                c.smooth_gain = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(3000, 30000));
                c.rise_threshold_mv = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                      : $urandom_range(0, 30));
                c.fall_threshold_mv = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                      : $urandom_range(0, 30));
                c.charger_level_mv = 13'($urandom_range(4100, 4500));
                c.boot_level_mv = 13'($urandom_range(4000, 4400));
                c.charging_offset_mv = 11'($urandom_range(0, 2047));
                c.resting_offset_mv = 9'($urandom_range(0, 511));
            end
        endcase
        write_register(bgcd_pkg::REG_FILTER_GAIN, c.filter_gain);
        write_register(bgcd_pkg::REG_SMOOTH_GAIN, c.smooth_gain);
        write_register(bgcd_pkg::REG_RISE_THRESHOLD, 16'(c.rise_threshold_mv));
        write_register(bgcd_pkg::REG_FALL_THRESHOLD, 16'(c.fall_threshold_mv));
        write_register(bgcd_pkg::REG_CHARGER_LEVEL, 16'(c.charger_level_mv));
        write_register(bgcd_pkg::REG_BOOT_LEVEL, 16'(c.boot_level_mv));
        write_register(bgcd_pkg::REG_CHARGING_OFFSET, 16'(c.charging_offset_mv));
        write_register(bgcd_pkg::REG_RESTING_OFFSET, 16'(c.resting_offset_mv));
    endtask

    // mostly a drifting cell voltage with plug/unplug steps, some noise and zero runs
    task automatic next_sample(output bgcd_pkg::in_t s);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (zero_run > 0)
        begin
            zero_run--;
            s.sample_mv = '0;
        end
        else if (r < 2)
        begin
            zero_run = 3;
            s.sample_mv = '0;
        end
        else if (r < 10)
        begin
            s.sample_mv = 13'($urandom_range(0, 8191));
        end
        else
        begin
            if (r < 14) track_mv = track_mv + int'($urandom_range(60, 400));
            else if (r < 18) track_mv = track_mv - int'($urandom_range(60, 400));
            else track_mv = track_mv + int'($urandom_range(0, 16)) - 8;
            if (track_mv < 2900) track_mv = 2900;
            if (track_mv > 4500) track_mv = 4500;
            s.sample_mv = 13'(track_mv);
        end
        s.manual_charging = ($urandom_range(0, 99) < 15);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            gauge.check_reading(out_data);
    end

    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(negedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        bgcd_pkg::in_t s;
        int unsigned directed_mv [DIRECTED_ITEMS];
        bit [DIRECTED_ITEMS-1:0] directed_manual;
        gauge = new();
        directed_mv = '{8191, 8191, 0, 0, 4300, 4300, 4300, 4150, 4000, 3700, 3500,
                        3300, 3000, 4100, 3900, 3600, 3400, 5000, 1, 4096, 2730, 5461};
        directed_manual = 22'b1010_1001_1000_0000_0010_10;
        steady = 1'b0;
        track_mv = 3800;
        zero_run = 0;
        stuck_cycles = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first transfer seeds the trend and guesses charging from the boot level
        for (int i = 0; i < DIRECTED_ITEMS; i++)
        begin
            s.sample_mv = 13'(directed_mv[i]);
            s.manual_charging = directed_manual[DIRECTED_ITEMS-1-i];
            send_sample(s);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            in_valid <= 1'b0;
            wait_drained();
            program_phase(p);
            steady = (p == 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                next_sample(s);
                send_sample(s);
            end
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (gauge.failures == 0 && gauge.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
